/* rtl/core/fbe_pkg.sv */
`default_nettype none

package fbe_pkg;

    // sample and register widths
    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 15;
    localparam int GAIN_W   = 15;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 1;

    // default echo line depth
    localparam int LINE_DEPTH_DEF = 16384;

    // register reset values
    localparam logic [DELAY_W-1:0] DELAY_RST = 15'd4410;
    localparam logic [GAIN_W-1:0]  GAIN_RST  = 15'd16384;

    // q15 rounding and saturation limits
    localparam logic signed [31:0]         ROUND_HALF = 32'sd16384;
    localparam logic signed [SAMPLE_W+1:0] SUM_MAX    = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] SUM_MIN    = -18'sd32768;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX    = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN    = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY = 1'b0,
        CFG_GAIN  = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

/* rtl/core/fbe_ram.sv */
`default_nettype none

module fbe_ram #(
    parameter int WIDTH = fbe_pkg::SAMPLE_W,
    parameter int DEPTH = fbe_pkg::LINE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/feedback_echo_delay.sv */
`default_nettype none

// Feedback echo on a stream of signed Q1.15 samples: y = sat(x + g * y[n - delay]),
// with g the unsigned Q0.15 feedback gain and delay the echo spacing in samples
// (0 acts as 1, values above LINE_DEPTH act as LINE_DEPTH). A transaction with
// drain set counts as a zero sample so the tail rings out. One transaction is
// accepted every clock unless o_stall holds it off; each gives exactly one result
// through the read stage and the output register. Past outputs live in a single
// LINE_DEPTH x 16 RAM with a registered read, read at accept, written from the read
// stage, newest write forwarded when a delay of one hits it. The line reads as zero
// after reset with no clearing pass: entries not yet written since reset are masked
// from the write pointer and a wrap flag. Configure only while the block is idle.
module feedback_echo_delay #(
    parameter int LINE_DEPTH = fbe_pkg::LINE_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input channel
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [fbe_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  wire logic                                 i_drain,
    // output channel
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed      [fbe_pkg::SAMPLE_W-1:0]  o_sample_out,
    // configuration
    input  wire logic                                 i_cfg_we,
    input  wire logic        [fbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [fbe_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = (AW + 1 > fbe_pkg::DELAY_W) ? AW + 1 : fbe_pkg::DELAY_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
    localparam logic [AW-1:0] WP_LAST = AW'(LINE_DEPTH - 1);

    // configuration registers
    logic [fbe_pkg::DELAY_W-1:0] r_delay;
    logic [fbe_pkg::GAIN_W-1:0]  r_gain;

    // write pointer and wrap flag (every entry written once wrapped)
    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic          r_wrap;

    // read stage
    logic                               r_s1_vld;
    logic [AW-1:0]                      r_s1_wp;
    logic signed [fbe_pkg::SAMPLE_W-1:0] r_s1_dry;
    logic                               r_s1_hit;
    logic                               r_s1_fwd;
    logic signed [fbe_pkg::SAMPLE_W-1:0] r_s1_fwd_y;

    // output register
    logic                               r_out_vld;
    logic signed [fbe_pkg::SAMPLE_W-1:0] r_out;

    logic                               in_acc;
    logic                               s1_go;
    logic [CW-1:0]                      d_ext;
    logic [CW-1:0]                      d_clamp;
    logic [CW-1:0]                      wp_ext;
    logic [CW-1:0]                      rd_ext;
    logic [AW-1:0]                      rd_addr;
    logic [fbe_pkg::SAMPLE_W-1:0]       ram_q;
    logic signed [fbe_pkg::SAMPLE_W-1:0] delayed;
    logic signed [31:0]                 prod;
    logic signed [31:0]                 prod_r;
    logic signed [fbe_pkg::SAMPLE_W:0]   echo;
    logic signed [fbe_pkg::SAMPLE_W+1:0] sum;
    logic signed [fbe_pkg::SAMPLE_W-1:0] s1_y;

    assign s1_go   = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_go;
    assign in_acc  = i_valid && !o_stall;

    // read address: wp - delay modulo depth
    always_comb begin
        d_ext = CW'(r_delay);
        if (d_ext == '0) begin
            d_clamp = CW'(1);
        end else if (d_ext > DEPTH_C) begin
            d_clamp = DEPTH_C;
        end else begin
            d_clamp = d_ext;
        end
        wp_ext = CW'(r_wp);
        if (wp_ext >= d_clamp) begin
            rd_ext = wp_ext - d_clamp;
        end else begin
            rd_ext = wp_ext + (DEPTH_C - d_clamp);
        end
        rd_addr = rd_ext[AW-1:0];
        n_wp    = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= fbe_pkg::DELAY_RST;
            r_gain  <= fbe_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (fbe_pkg::t_cfg_idx'(i_cfg_index))
                fbe_pkg::CFG_DELAY: r_delay <= i_cfg_data[fbe_pkg::DELAY_W-1:0];
                fbe_pkg::CFG_GAIN:  r_gain  <= i_cfg_data[fbe_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrap    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_wp <= n_wp;
                if (r_wp == WP_LAST) begin
                    r_wrap <= 1'b1;
                end
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_wp  <= r_wp;
            r_s1_dry <= i_drain ? '0 : i_sample_in;
            r_s1_hit <= r_wrap || (rd_addr < r_wp);
            // previous transaction writes the entry being read on this edge
            r_s1_fwd   <= s1_go && (rd_addr == r_s1_wp);
            r_s1_fwd_y <= s1_y;
        end
        if (s1_go) begin
            r_out <= s1_y;
        end
    end

    fbe_ram #(
        .WIDTH (fbe_pkg::SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_wp),
        .i_wdata (s1_y),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // scale, add and saturate
    always_comb begin
        if (r_s1_fwd) begin
            delayed = r_s1_fwd_y;
        end else if (r_s1_hit) begin
            delayed = $signed(ram_q);
        end else begin
            delayed = '0;
        end
        prod   = 32'(delayed) * $signed({17'd0, r_gain});
        prod_r = prod + fbe_pkg::ROUND_HALF;
        echo   = prod_r[31:15];
        sum    = 18'(echo) + 18'(r_s1_dry);
        if (sum > fbe_pkg::SUM_MAX) begin
            s1_y = fbe_pkg::SAT_MAX;
        end else if (sum < fbe_pkg::SUM_MIN) begin
            s1_y = fbe_pkg::SAT_MIN;
        end else begin
            s1_y = sum[fbe_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_sample_out = r_out;

endmodule

`default_nettype wire

/* rtl/core/fbe_checker.sv */
`default_nettype none

module fbe_props (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic signed [fbe_pkg::SAMPLE_W-1:0]  o_sample_out
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sample_out)))
        else $error("stalled result changed");

    // input is only held off by a full pipe behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without output backpressure");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // no result appears without an accepted transaction behind it
    a_no_phantom: assert property (@(posedge i_clk)
        (!i_rst_n ##1 (i_rst_n && !(i_valid && !o_stall))) |=> !o_valid)
        else $error("result without accepted transaction");

endmodule

bind feedback_echo_delay fbe_props u_fbe_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample_out (o_sample_out)
);

`default_nettype wire
